/* hw/rtl/gha_pkg.sv */
// Shared types and constants of the generational handle allocator.
// No dependencies; imported by every module of the block.
package gha_pkg;

    localparam int POOL_DEPTH_DEF = 1024;
    localparam int GEN_BITS_DEF   = 16;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REUSE
    } t_state;

    // Control of the free-slot queue.
    typedef struct packed {
        logic rd;     // read the head entry into the head register
        logic push;   // append an entry at the tail
        logic pop;    // drop the head entry
        logic flush;  // empty the queue
    } t_fq_ctrl;

endpackage

/* hw/rtl/gha_ram.sv */
// Simple dual-port synchronous RAM, one write port, one registered read port.
// Depends on gha_pkg for default sizes.
module gha_ram
    import gha_pkg::*;
#(
    parameter int WIDTH = GEN_BITS_DEF + 1,
    parameter int DEPTH = POOL_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gha_free_queue.sv */
// Ring queue of freed slot indexes: head/tail pointers, fill count, RAM storage.
// Depends on gha_pkg and gha_ram.
module gha_free_queue
    import gha_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int IDX_W      = $clog2(POOL_DEPTH),
    parameter int CNT_W      = $clog2(POOL_DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fq_ctrl         i_ctrl,
    input  logic [IDX_W-1:0] i_push_data,
    output logic [IDX_W-1:0] o_head_data,
    output logic [CNT_W-1:0] o_count
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(POOL_DEPTH - 1);

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctrl.flush) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else begin
            if (i_ctrl.push) begin
                n_tail  = (r_tail == LAST) ? '0 : r_tail + 1'b1;
                n_count = r_count + 1'b1;
            end
            if (i_ctrl.pop) begin
                n_head  = (r_head == LAST) ? '0 : r_head + 1'b1;
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    gha_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH),
        .AW    (IDX_W)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.push),
        .i_waddr (r_tail),
        .i_wdata (i_push_data),
        .i_re    (i_ctrl.rd),
        .i_raddr (r_head),
        .o_rdata (o_head_data)
    );

    assign o_count = r_count;

endmodule

/* hw/rtl/generational_handle_allocator_top.sv */
// Generational handle allocator, top level: command sequencer, slot RAM, output register.
// Depends on gha_pkg, gha_ram and gha_free_queue.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command item: create,
//   delete, check or clear, with a handle (slot index + generation) for delete
//   and check. Output channel (o_out_valid / i_out_ready) returns one result
//   item per command: status, new handle for create, active slot count.
//   Config channel (i_cfg_valid / o_cfg_ready) writes max_nodes; write it
//   only while no command is in flight. o_cfg_ready is always high.
// Sequencing:
//   The result is registered from the execute step, or from the reuse step
//   for a create that reuses a freed slot (free-queue RAM read, then slot RAM read).
//   One item is in flight at a time and o_in_ready returns as the result is
//   registered, so a new command is not taken until the last one is done.
// Reset: pool and free queue empty, max_nodes = POOL_DEPTH. RAM contents are
//   kept: the high-water mark bounds which slot entries are live.
// Stall:
//   A waiting result does not block the next accept; a finished command holds
//   in its last step until the output register frees up.
module generational_handle_allocator_top
    import gha_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF,
    parameter int GEN_BITS   = GEN_BITS_DEF,
    parameter int IDX_W      = $clog2(POOL_DEPTH),
    parameter int CNT_W      = $clog2(POOL_DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command items
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_cmd,
    input  logic [IDX_W-1:0]    i_handle_index,
    input  logic [GEN_BITS-1:0] i_handle_generation,
    // result items
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [IDX_W-1:0]    o_out_index,
    output logic [GEN_BITS-1:0] o_out_generation,
    output logic [CNT_W-1:0]    o_active_count,
    // max_nodes write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CNT_W-1:0]    i_cfg_data
);

    localparam logic [CNT_W-1:0] POOL_FULL = CNT_W'(POOL_DEPTH);

    // Sequencer state and latched command.
    t_state                r_state, n_state;
    t_cmd                  r_cmd;
    logic [IDX_W-1:0]      r_idx;
    logic [GEN_BITS-1:0]   r_gen;
    logic [IDX_W-1:0]      r_slot, n_slot;
    logic [CNT_W-1:0]      r_hw, n_hw;
    logic [CNT_W-1:0]      r_max_nodes;

    // Output register.
    logic                  r_out_valid;
    t_status               r_status;
    logic [IDX_W-1:0]      r_out_index;
    logic [GEN_BITS-1:0]   r_out_generation;
    logic [CNT_W-1:0]      r_active_count;

    // Result being loaded this cycle.
    logic                  load_out;
    t_status               res_status;
    logic [IDX_W-1:0]      res_idx;
    logic [GEN_BITS-1:0]   res_gen;
    logic [CNT_W-1:0]      res_cnt;

    // Slot RAM: {active, generation} per slot.
    logic                  slot_we, slot_re;
    logic [IDX_W-1:0]      slot_waddr, slot_raddr;
    logic [GEN_BITS:0]     slot_wdata, slot_rdata;
    logic [GEN_BITS-1:0]   rd_gen, next_gen;
    logic                  rd_act;

    // Free queue.
    t_fq_ctrl              q_ctrl;
    logic [IDX_W-1:0]      q_head;
    logic [CNT_W-1:0]      q_count;

    logic                  in_fire, out_free;
    logic [CNT_W-1:0]      active;
    logic                  is_full, hnd_ok;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign rd_gen   = slot_rdata[GEN_BITS-1:0];
    assign rd_act   = slot_rdata[GEN_BITS];
    // Step the generation; skip zero on wrap.
    assign next_gen = (rd_gen + 1'b1 == '0) ? GEN_BITS'(1) : rd_gen + 1'b1;

    assign active  = r_hw - q_count;
    assign is_full = (active >= r_max_nodes) || (q_count == '0 && r_hw == POOL_FULL);
    // Valid handle: nonzero generation, below the high-water mark, live, same generation.
    assign hnd_ok  = (r_gen != '0) && (CNT_W'(r_idx) < r_hw) && rd_act && (rd_gen == r_gen);

    always_comb begin
        n_state    = r_state;
        n_hw       = r_hw;
        n_slot     = r_slot;
        load_out   = 1'b0;
        res_status = ST_OK;
        res_idx    = '0;
        res_gen    = '0;
        res_cnt    = active;
        slot_we    = 1'b0;
        slot_waddr = r_idx;
        slot_wdata = {1'b0, r_gen};
        slot_re    = 1'b0;
        slot_raddr = i_handle_index;
        q_ctrl     = '0;
        case (r_state)
            S_IDLE: begin
                // Fetch the handle's slot entry and the free-queue head together.
                if (in_fire) begin
                    slot_re   = 1'b1;
                    q_ctrl.rd = 1'b1;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_CREATE: begin
                        if (is_full) begin
                            if (out_free) begin
                                load_out   = 1'b1;
                                res_status = ST_FULL;
                                n_state    = S_IDLE;
                            end
                        end else if (q_count == '0) begin
                            // Take the next never-used slot at generation 1.
                            if (out_free) begin
                                slot_we    = 1'b1;
                                slot_waddr = r_hw[IDX_W-1:0];
                                slot_wdata = {1'b1, GEN_BITS'(1)};
                                n_hw       = r_hw + 1'b1;
                                load_out   = 1'b1;
                                res_idx    = r_hw[IDX_W-1:0];
                                res_gen    = GEN_BITS'(1);
                                res_cnt    = active + 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            // Reuse the oldest freed slot: read its generation next.
                            slot_re    = 1'b1;
                            slot_raddr = q_head;
                            q_ctrl.pop = 1'b1;
                            n_slot     = q_head;
                            n_state    = S_REUSE;
                        end
                    end
                    CMD_DELETE: begin
                        if (out_free) begin
                            load_out = 1'b1;
                            if (hnd_ok) begin
                                slot_we     = 1'b1;
                                q_ctrl.push = 1'b1;
                                res_cnt     = active - 1'b1;
                            end else begin
                                res_status = ST_INVALID;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_CHECK: begin
                        if (out_free) begin
                            load_out   = 1'b1;
                            res_status = hnd_ok ? ST_OK : ST_INVALID;
                            n_state    = S_IDLE;
                        end
                    end
                    CMD_CLEAR: begin
                        // Dropping the high-water mark retires every slot entry.
                        if (out_free) begin
                            load_out     = 1'b1;
                            n_hw         = '0;
                            q_ctrl.flush = 1'b1;
                            res_cnt      = '0;
                            n_state      = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_REUSE: begin
                // Queue count is already decremented here.
                if (out_free) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_slot;
                    slot_wdata = {1'b1, next_gen};
                    load_out   = 1'b1;
                    res_idx    = r_slot;
                    res_gen    = next_gen;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hw        <= '0;
            r_max_nodes <= POOL_FULL;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hw    <= n_hw;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_nodes <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (in_fire) begin
            r_cmd <= t_cmd'(i_cmd);
            r_idx <= i_handle_index;
            r_gen <= i_handle_generation;
        end
        if (load_out) begin
            r_status         <= res_status;
            r_out_index      <= res_idx;
            r_out_generation <= res_gen;
            r_active_count   <= res_cnt;
        end
    end

    gha_ram #(
        .WIDTH (GEN_BITS + 1),
        .DEPTH (POOL_DEPTH),
        .AW    (IDX_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    gha_free_queue #(
        .POOL_DEPTH (POOL_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_free_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (q_ctrl),
        .i_push_data (r_idx),
        .o_head_data (q_head),
        .o_count     (q_count)
    );

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_out_index      = r_out_index;
    assign o_out_generation = r_out_generation;
    assign o_active_count   = r_active_count;

endmodule

/* test/gha_checker.sv */
// Result checker for the generational handle allocator testbench.
// Watches the command, result and max_nodes channels, keeps its own pool state
// and compares every result item in order. Depends on gha_pkg only.
module gha_checker
    import gha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [9:0]  i_handle_index,
    input  logic [15:0] i_handle_generation,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [9:0]  i_out_index,
    input  logic [15:0] i_out_generation,
    input  logic [10:0] i_active_count,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [10:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status     status;
        logic [9:0]  index;
        logic [15:0] generation;
        logic [10:0] count;
    } t_result;

    // Shadow pool.
    logic [15:0] gen_mem [1024];
    logic        live_mem [1024];
    logic [9:0]  free_ring [1024];
    logic [9:0]  ring_head;
    logic [9:0]  ring_tail;
    logic [10:0] free_cnt;
    logic [10:0] high_mark;
    logic [10:0] node_limit;

    t_result results_due [$];
    int      fails = 0;

    function automatic logic handle_live(logic [9:0] idx, logic [15:0] gen);
        return gen != 16'd0 && {1'b0, idx} < high_mark && live_mem[idx] &&
               gen_mem[idx] == gen;
    endfunction

    // Apply one command to the shadow pool and return its result item.
    function automatic t_result run_command(t_cmd op, logic [9:0] idx, logic [15:0] gen);
        t_result     res;
        logic [9:0]  slot;
        logic [15:0] next_gen;
        res = '{status: ST_OK, index: '0, generation: '0, count: '0};
        case (op)
            CMD_CREATE: begin
                if (high_mark - free_cnt >= node_limit ||
                    (free_cnt == 0 && high_mark >= 11'd1024)) begin
                    res.status = ST_FULL;
                end else begin
                    if (free_cnt != 0) begin
                        slot      = free_ring[ring_head];
                        ring_head = ring_head + 10'd1;
                        free_cnt  = free_cnt - 11'd1;
                        next_gen  = gen_mem[slot] + 16'd1;
                        // skip zero on wrap, it marks an invalid handle
                        if (next_gen == 16'd0)
                            next_gen = 16'd1;
                    end else begin
                        slot      = high_mark[9:0];
                        high_mark = high_mark + 11'd1;
                        next_gen  = 16'd1;
                    end
                    gen_mem[slot]  = next_gen;
                    live_mem[slot] = 1'b1;
                    res.index      = slot;
                    res.generation = next_gen;
                end
            end
            CMD_DELETE: begin
                if (handle_live(idx, gen)) begin
                    live_mem[idx]        = 1'b0;
                    free_ring[ring_tail] = idx;
                    ring_tail            = ring_tail + 10'd1;
                    free_cnt             = free_cnt + 11'd1;
                end else begin
                    res.status = ST_INVALID;
                end
            end
            CMD_CHECK: begin
                if (!handle_live(idx, gen))
                    res.status = ST_INVALID;
            end
            default: begin
                foreach (live_mem[i])
                    live_mem[i] = 1'b0;
                ring_head = '0;
                ring_tail = '0;
                free_cnt  = '0;
                high_mark = '0;
            end
        endcase
        res.count = high_mark - free_cnt;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result due;
        if (!i_rst_n) begin
            foreach (live_mem[i])
                live_mem[i] = 1'b0;
            ring_head  = '0;
            ring_tail  = '0;
            free_cnt   = '0;
            high_mark  = '0;
            node_limit = 11'd1024;
            results_due.delete();
        end else begin
            // compare first: a result leaving now always belongs to an older item
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $error("result item with no command waiting");
                    fails++;
                end else begin
                    due = results_due.pop_front();
                    if (i_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, i_status);
                        fails++;
                    end
                    if (i_out_index !== due.index) begin
                        $error("out_index: expected %0d, got %0d", due.index, i_out_index);
                        fails++;
                    end
                    if (i_out_generation !== due.generation) begin
                        $error("out_generation: expected %0d, got %0d",
                               due.generation, i_out_generation);
                        fails++;
                    end
                    if (i_active_count !== due.count) begin
                        $error("active_count: expected %0d, got %0d",
                               due.count, i_active_count);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                node_limit = i_cfg_data;
            if (i_in_valid && i_in_ready)
                results_due.insert(results_due.size(),
                                   run_command(t_cmd'(i_cmd), i_handle_index,
                                               i_handle_generation));
        end
        o_fail_count <= fails;
        o_pending    <= results_due.size();
    end

endmodule

/* test/tb_top.sv */
// Top of the generational handle allocator testbench: clock, reset, stimulus, verdict.
// Depends on gha_pkg, generational_handle_allocator_top and gha_checker.
module tb_top;
    import gha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [9:0]  idx;
        logic [15:0] gen;
    } t_handle;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = CMD_CREATE;
    logic [9:0]  i_handle_index = '0;
    logic [15:0] i_handle_generation = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [9:0]  o_out_index;
    logic [15:0] o_out_generation;
    logic [10:0] o_active_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    int fail_count;
    int pending;

    // Idling controls: calm means no gaps at all on that side.
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit rx_hold_req = 1'b0;
    int rx_stall_left = 0;

    // Handles seen coming back from creates, and handles already deleted.
    t_handle live_handles [$];
    t_handle retired_handles [$];

    generational_handle_allocator_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_cmd               (i_cmd),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_status            (o_status),
        .o_out_index         (o_out_index),
        .o_out_generation    (o_out_generation),
        .o_active_count      (o_active_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data)
    );

    gha_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_cmd               (i_cmd),
        .i_handle_index      (i_handle_index),
        .i_handle_generation (i_handle_generation),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_status            (o_status),
        .i_out_index         (o_out_index),
        .i_out_generation    (o_out_generation),
        .i_active_count      (o_active_count),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    always #5 i_clk = ~i_clk;

    // Result side: random stalls, mostly short, now and then long, plus the
    // one long hold-off that fills the block and backs up the command side.
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_stall_left = 300;
            rx_hold_req <= 1'b0;
        end
        if (rx_stall_left > 0) begin
            i_out_ready <= 1'b0;
            rx_stall_left--;
        end else if (rx_calm || $urandom_range(0, 3) != 0) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            rx_stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 50)
                                                         : $urandom_range(0, 3);
        end
    end

    // Learn handles from successful creates; keep the list short.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready && o_status == ST_OK &&
            o_out_generation != 16'd0) begin
            live_handles.insert(live_handles.size(),
                                t_handle'{idx: o_out_index, gen: o_out_generation});
            if (live_handles.size() > 64)
                void'(live_handles.pop_front());
        end
    end

    function automatic int command_gap();
        int r;
        r = $urandom_range(0, 15);
        if (tx_calm || r < 9)
            return 0;
        if (r < 14)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one command item, hold it until accepted, then maybe idle.
    // Valid is left high when the next item follows at once.
    task automatic send(t_cmd op, logic [9:0] idx, logic [15:0] gen);
        int gap;
        i_in_valid          <= 1'b1;
        i_cmd               <= op;
        i_handle_index      <= idx;
        i_handle_generation <= gen;
        do @(posedge i_clk); while (!o_in_ready);
        gap = command_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait until every command has returned its result.
    // The pending count is registered in the checker.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_node_limit(logic [10:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_cmd delete_or_check();
        return ($urandom_range(0, 1) != 0) ? CMD_DELETE : CMD_CHECK;
    endfunction

    // One random command: mostly well-formed use of known handles, the rest
    // stale, corrupted or zero-generation handles and the odd clear.
    task automatic random_command();
        int      r;
        int      k;
        t_handle h;
        r = $urandom_range(0, 99);
        if (r < 38 || (r < 78 && live_handles.size() == 0)) begin
            send(CMD_CREATE, 10'($urandom), 16'($urandom));
        end else if (r < 60) begin
            k = $urandom_range(0, live_handles.size() - 1);
            h = live_handles[k];
            live_handles.delete(k);
            retired_handles.insert(retired_handles.size(), h);
            if (retired_handles.size() > 64)
                void'(retired_handles.pop_front());
            send(CMD_DELETE, h.idx, h.gen);
        end else if (r < 78) begin
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            send(CMD_CHECK, h.idx, h.gen);
        end else if (r < 88 && retired_handles.size() != 0) begin
            h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
            send(delete_or_check(), h.idx, h.gen);
        end else if (r < 96) begin
            send(delete_or_check(), 10'($urandom),
                 ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom));
        end else if (r < 98) begin
            send(CMD_CLEAR, 10'($urandom), 16'($urandom));
            live_handles.delete();
        end else if (live_handles.size() != 0) begin
            // off-by-one generation on a live slot
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
            send(CMD_CHECK, h.idx, h.gen + 16'd1);
        end else begin
            send(CMD_CHECK, 10'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [10:0] phase_limit [7];
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_node_limit(11'd1024);

        // Basic create, check, delete and reuse on the first two slots.
        send(CMD_CREATE, 10'd0, 16'd0);
        send(CMD_CREATE, 10'h3FF, 16'hFFFF);
        send(CMD_CHECK, 10'd0, 16'd1);
        send(CMD_CHECK, 10'd1, 16'd2);
        send(CMD_CHECK, 10'd0, 16'd0);
        send(CMD_DELETE, 10'd0, 16'd1);
        send(CMD_DELETE, 10'd0, 16'd1);
        send(CMD_CHECK, 10'd0, 16'd1);
        send(CMD_CREATE, 10'd0, 16'd0);
        send(CMD_CHECK, 10'd0, 16'd2);

        // Fill up to a small limit, one more create is refused, then reuse
        // freed slots in the order they were deleted.
        write_node_limit(11'd3);
        send(CMD_CLEAR, 10'd0, 16'd0);
        repeat (4)
            send(CMD_CREATE, 10'($urandom), 16'($urandom));
        send(CMD_CHECK, 10'd2, 16'd1);
        send(CMD_DELETE, 10'd2, 16'd1);
        send(CMD_DELETE, 10'd1, 16'd1);
        send(CMD_CREATE, 10'd0, 16'd0);
        send(CMD_CREATE, 10'd0, 16'd0);
        send(CMD_CHECK, 10'd2, 16'd2);
        send(CMD_CREATE, 10'd0, 16'd0);
        write_node_limit(11'd1024);

        // Index at or above the high-water mark, zero generation.
        send(CMD_CLEAR, 10'h3FF, 16'hFFFF);
        send(CMD_CHECK, 10'd0, 16'd1);
        send(CMD_CREATE, 10'd0, 16'd0);
        send(CMD_CHECK, 10'd1, 16'd1);
        send(CMD_CHECK, 10'h3FF, 16'hFFFF);
        send(CMD_DELETE, 10'd0, 16'd0);
        send(CMD_DELETE, 10'd0, 16'd1);

        // Zero limit: every create is refused.
        write_node_limit(11'd0);
        send(CMD_CREATE, 10'd0, 16'd0);
        send(CMD_CHECK, 10'd0, 16'd1);
        settle();
        live_handles.delete();
        retired_handles.delete();

        // Random phases across limit settings, extremes included.
        phase_limit = '{11'd1024, 11'd3, 11'd0, 11'd1023, 11'd1, 11'd17,
                        11'($urandom_range(2, 64))};
        foreach (phase_limit[p]) begin
            write_node_limit(phase_limit[p]);
            tx_calm = (p % 3 == 2);
            rx_calm = (p % 4 == 3);
            for (int n = 0; n < 100; n++) begin
                if (p == 0 && n == 20)
                    rx_hold_req <= 1'b1;
                random_command();
            end
        end

        // Drain, then give the verdict.
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; n < 5000 && pending != 0; n++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #40_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
